// ----- rtl/core/pca_pkg.sv -----
package pca_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int POS_BITS_DEF   = 32;

    localparam int IN_POS_BITS    = 32;
    localparam int BASE_BITS      = 8;
    localparam int RED_BITS       = 8;
    localparam int QPOS_BITS      = 16;
    localparam int CNT_OUT_BITS   = 16;
    localparam int REPEAT_BITS    = 24;
    localparam int POS_OUT_BITS   = 32;

    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int REG_IDX_LSB    = 2;
    localparam int REG_IDX_BITS   = CFG_ADDR_BITS - REG_IDX_LSB;

    localparam logic [REG_IDX_BITS-1:0] REG_TOTAL_MODE = REG_IDX_BITS'(0);

    typedef struct packed {
        logic [IN_POS_BITS-1:0] position;
        logic [BASE_BITS-1:0]   base_char;
        logic                   has_alignment;
        logic                   is_deletion;
        logic [RED_BITS-1:0]    redundancy;
        logic                   reversed;
        logic [QPOS_BITS-1:0]   query_position;
        logic [QPOS_BITS-1:0]   read_len;
        logic                   last_in_position;
    } t_in_req;

    typedef struct packed {
        logic [POS_OUT_BITS-1:0] out_position;
        logic [BASE_BITS-1:0]    out_base_char;
        logic [CNT_OUT_BITS-1:0] unique_top;
        logic [CNT_OUT_BITS-1:0] unique_bot;
        logic [REPEAT_BITS-1:0]  repeat_top;
        logic [REPEAT_BITS-1:0]  repeat_bot;
        logic [CNT_OUT_BITS-1:0] raw_repeat_top;
        logic [CNT_OUT_BITS-1:0] raw_repeat_bot;
        logic [CNT_OUT_BITS-1:0] begin_top;
        logic [CNT_OUT_BITS-1:0] begin_bot;
        logic [POS_OUT_BITS-1:0] skipped_positions;
        logic [POS_OUT_BITS-1:0] region_positions;
    } t_out_req;

endpackage

// ----- rtl/core/pileup_coverage_accumulator.sv -----
// Pileup coverage accumulator.
// The input channel (i_in_valid, o_in_stall, i_in_req) takes one pileup entry per
// request; entries of one reference position arrive together, the final one marked.
// The output channel (o_out_valid, i_out_stall, o_out_req) gives one coverage row
// for each final entry with a nonzero position, nothing for other entries.
// Total mode is set through the APB-style port, register 0 at byte address 0.
// An entry with position zero is dropped and the input is ready the next cycle.
// A unique read, a read with redundancy zero, a deletion or an empty entry passes
// through the accumulate state, and also through the emit state if it closes a row.
// Any other redundant read passes through the divide state before them: its reciprocal
// comes from a serial restoring divider that produces one quotient bit per cycle.
// A row is written to the output register from the emit state, which follows the
// accumulate state of its final entry.
// The row sits in an output register; the next entry is taken while it waits.
// A final entry whose row finds the output register still full holds the input
// stalled until the receiver takes the earlier row.
// Synchronous reset clears all counts, the last position, the region total
// and total mode, and empties the output register.
module pileup_coverage_accumulator #(
    parameter int COUNT_BITS = pca_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = pca_pkg::FRAC_BITS_DEF,
    parameter int POS_BITS   = pca_pkg::POS_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pca_pkg::t_in_req                    i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pca_pkg::t_out_req                   o_out_req,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pca_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [pca_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [pca_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import pca_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int PW = ((POS_BITS > POS_OUT_BITS) ? POS_BITS : POS_OUT_BITS) + 1;
    localparam int TW = PW + 1;
    localparam int CW = ((COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS) + 1;
    localparam int RW = FRAC_BITS + 1;
    localparam int SW = ((REPEAT_BITS > RW) ? REPEAT_BITS : RW) + 1;

    localparam logic [RW-1:0]           ONE_FIX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [REPEAT_BITS-1:0]  REP_MAX  = '1;
    localparam logic [POS_BITS-1:0]     POS_MAX  = '1;
    localparam logic [CNT_OUT_BITS-1:0] CNT_OMAX = '1;
    localparam logic [POS_OUT_BITS-1:0] POS_OMAX = '1;

    function automatic logic [CNT_OUT_BITS-1:0] clamp_cnt(input logic [CW-1:0] v);
        return (v > CW'(CNT_OMAX)) ? CNT_OMAX : v[CNT_OUT_BITS-1:0];
    endfunction

    function automatic logic [REPEAT_BITS-1:0] clamp_rep(input logic [SW-1:0] v);
        return (v > SW'(REP_MAX)) ? REP_MAX : v[REPEAT_BITS-1:0];
    endfunction

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    t_in_req                r_item;
    logic [COUNT_BITS-1:0]  r_uniq [2];
    logic [COUNT_BITS-1:0]  r_raw  [2];
    logic [COUNT_BITS-1:0]  r_beg  [2];
    logic [REPEAT_BITS-1:0] r_rep  [2];
    logic [POS_BITS-1:0]    r_last_pos;
    logic [POS_BITS-1:0]    r_total;
    logic [PW-1:0]          r_skip;
    logic                   r_out_valid;
    t_out_req               r_out;

    logic                   total_mode;
    logic                   in_acc;
    logic                   in_used;
    logic                   in_div;
    logic                   div_done;
    logic [FRAC_BITS-1:0]   div_quot;

    logic                   strand;
    logic                   contrib;
    logic                   first_base;
    logic [RW-1:0]          recip;
    logic [SW-1:0]          rep_sum;
    logic [PW-1:0]          pos_w;
    logic [PW-1:0]          last_w;
    logic [PW-1:0]          skip_calc;
    logic [TW-1:0]          tot_sum;
    logic [POS_BITS-1:0]    tot_next;
    logic [PW-1:0]          region_w;
    logic                   out_free;
    t_out_req               row;

    pca_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_total_mode (total_mode)
    );

    pca_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_div),
        .i_divisor (i_in_req.redundancy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_used    = in_acc && (i_in_req.position != '0);
    assign in_div     = in_used && i_in_req.has_alignment && !i_in_req.is_deletion &&
                        (i_in_req.redundancy != RED_BITS'(0)) &&
                        (i_in_req.redundancy != RED_BITS'(1));
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        strand     = r_item.reversed;
        contrib    = r_item.has_alignment && !r_item.is_deletion;
        first_base = strand ? (r_item.query_position == r_item.read_len)
                            : (r_item.query_position == QPOS_BITS'(1));
        recip      = (r_item.redundancy == RED_BITS'(0)) ? ONE_FIX : {1'b0, div_quot};
        rep_sum    = SW'(r_rep[strand]) + SW'(recip);
        pos_w      = PW'(r_item.position);
        last_w     = PW'(r_last_pos);
        skip_calc  = (pos_w > last_w + PW'(1)) ? (pos_w - last_w - PW'(1)) : '0;
        tot_sum    = TW'(r_total) + TW'(r_skip) + TW'(1);
        tot_next   = (tot_sum > TW'(POS_MAX)) ? POS_MAX : tot_sum[POS_BITS-1:0];
        region_w   = PW'(tot_next);
    end

    always_comb begin
        row.out_position      = r_item.position;
        row.out_base_char     = r_item.base_char;
        row.skipped_positions = r_skip[POS_OUT_BITS-1:0];
        row.region_positions  = (region_w > PW'(POS_OMAX)) ? POS_OMAX
                                                          : region_w[POS_OUT_BITS-1:0];
        if (total_mode) begin
            row.unique_top     = clamp_cnt(CW'(r_uniq[0]) + CW'(r_uniq[1]));
            row.unique_bot     = '0;
            row.repeat_top     = clamp_rep(SW'(r_rep[0]) + SW'(r_rep[1]));
            row.repeat_bot     = '0;
            row.raw_repeat_top = clamp_cnt(CW'(r_raw[0]) + CW'(r_raw[1]));
            row.raw_repeat_bot = '0;
            row.begin_top      = clamp_cnt(CW'(r_beg[0]) + CW'(r_beg[1]));
            row.begin_bot      = '0;
        end else begin
            row.unique_top     = clamp_cnt(CW'(r_uniq[0]));
            row.unique_bot     = clamp_cnt(CW'(r_uniq[1]));
            row.repeat_top     = r_rep[0];
            row.repeat_bot     = r_rep[1];
            row.raw_repeat_top = clamp_cnt(CW'(r_raw[0]));
            row.raw_repeat_bot = clamp_cnt(CW'(r_raw[1]));
            row.begin_top      = clamp_cnt(CW'(r_beg[0]));
            row.begin_bot      = clamp_cnt(CW'(r_beg[1]));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_used) begin
                    n_state = in_div ? ST_DIV : ST_ACC;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = r_item.last_in_position ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_last_pos  <= '0;
            r_total     <= '0;
            for (int s = 0; s < 2; s++) begin
                r_uniq[s] <= '0;
                r_raw[s]  <= '0;
                r_beg[s]  <= '0;
                r_rep[s]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC && contrib) begin
                if (r_item.redundancy == RED_BITS'(1)) begin
                    if (r_uniq[strand] != '1) begin
                        r_uniq[strand] <= r_uniq[strand] + COUNT_BITS'(1);
                    end
                    if (first_base && r_beg[strand] != '1) begin
                        r_beg[strand] <= r_beg[strand] + COUNT_BITS'(1);
                    end
                end else begin
                    if (r_raw[strand] != '1) begin
                        r_raw[strand] <= r_raw[strand] + COUNT_BITS'(1);
                    end
                    r_rep[strand] <= clamp_rep(rep_sum);
                end
            end
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_total     <= tot_next;
                r_last_pos  <= POS_BITS'(r_item.position);
                for (int s = 0; s < 2; s++) begin
                    r_uniq[s] <= '0;
                    r_raw[s]  <= '0;
                    r_beg[s]  <= '0;
                    r_rep[s]  <= '0;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_used) begin
            r_item <= i_in_req;
        end
        if (r_state == ST_ACC) begin
            r_skip <= skip_calc;
        end
        if (r_state == ST_EMIT && out_free) begin
            r_out <= row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

// ----- rtl/core/pca_div.sv -----
module pca_div #(
    parameter int FRAC_BITS = pca_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pca_pkg::RED_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [FRAC_BITS-1:0]          o_quot
);
    import pca_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [RED_BITS-1:0] r_div;
    logic [RED_BITS-1:0] r_rem;
    logic [FRAC_BITS-1:0] r_quot;

    logic [RED_BITS:0]   shifted;
    logic                ge;
    logic [RED_BITS:0]   diff;
    logic [RED_BITS-1:0] n_rem;

    // The divisor is at least two, so the leading one of the dividend
    // leaves a remainder of one and a zero quotient bit.
    always_comb begin
        shifted = {r_rem, 1'b0};
        ge      = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
        n_rem   = ge ? diff[RED_BITS-1:0] : shifted[RED_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= RED_BITS'(1);
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[FRAC_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/pca_cfg.sv -----
module pca_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pca_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [pca_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [pca_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output logic                                o_total_mode
);
    import pca_pkg::*;

    logic                    r_total_mode;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr;

    assign reg_idx = paddr[CFG_ADDR_BITS-1:REG_IDX_LSB];
    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_mode <= 1'b0;
        end else if (wr && reg_idx == REG_TOTAL_MODE) begin
            r_total_mode <= pwdata[0];
        end
    end

    assign prdata = (reg_idx == REG_TOTAL_MODE) ?
                    {{(CFG_DATA_BITS-1){1'b0}}, r_total_mode} : '0;
    assign o_total_mode = r_total_mode;

endmodule

// ----- rtl/core/pca_chk.sv -----
module pca_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input pca_pkg::t_in_req                    i_in_req,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input pca_pkg::t_out_req                   o_out_req,
    input logic                                pready
);
    import pca_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("Stalled result changed or dropped.");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_req.position != '0 |=> o_in_stall)
        else $error("Input not stalled while a request is in work.");

    a_row_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.out_position != '0 &&
                        o_out_req.region_positions != '0)
        else $error("Result row with zero position or empty region.");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("Configuration port not ready.");

endmodule

bind pileup_coverage_accumulator pca_chk u_pca_chk (.*);

// ----- sim/pileup_coverage_accumulator_test.sv -----
module pileup_coverage_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pca_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam longint unsigned ONE_Q16 = 64'd1 << FRAC_BITS_DEF;
    localparam logic [CFG_ADDR_BITS-1:0] TOTAL_MODE_ADDR =
        CFG_ADDR_BITS'(REG_TOTAL_MODE) << REG_IDX_LSB;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_req                  i_in_req = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_req                 o_out_req;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    bit        total_mode_q = 1'b0;
    bit [31:0] last_pos_q = '0;
    bit [31:0] region_cnt = '0;
    bit [15:0] uniq_cnt[2] = '{default: '0};
    bit [15:0] raw_cnt[2] = '{default: '0};
    bit [15:0] begin_cnt[2] = '{default: '0};
    bit [23:0] rep_sum[2] = '{default: '0};
    t_out_req  expected_rows[$];
    int        failures = 0;
    bit        steady = 1'b0;
    int        hold_cycles = 0;

    pileup_coverage_accumulator u_top (.*);

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    initial begin : run_limit
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [15:0] count_up(bit [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic bit [15:0] clamp16(longint unsigned v);
        return (v > 64'hFFFF) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic bit [23:0] add_repeat(longint unsigned a, longint unsigned b);
        return (a + b > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(a + b);
    endfunction

    function automatic bit [31:0] following_pos();
        return (last_pos_q == 32'hFFFF_FFFF) ? 32'd1 : last_pos_q + 32'd1;
    endfunction

    function automatic void accumulate_coverage(t_in_req r);
        t_out_req row;
        int s;
        longint unsigned recip;
        longint unsigned skip;
        longint unsigned region;
        if (r.position == '0) return;
        s = int'(r.reversed);
        if (r.has_alignment && !r.is_deletion) begin
            if (r.redundancy == 8'd1) begin
                uniq_cnt[s] = count_up(uniq_cnt[s]);
                if (r.reversed ? (r.query_position == r.read_len)
                               : (r.query_position == 16'd1))
                    begin_cnt[s] = count_up(begin_cnt[s]);
            end else begin
                recip = (r.redundancy == 8'd0) ? ONE_Q16 : ONE_Q16 / r.redundancy;
                raw_cnt[s] = count_up(raw_cnt[s]);
                rep_sum[s] = add_repeat(rep_sum[s], recip);
            end
        end
        if (!r.last_in_position) return;
        skip = (64'(r.position) > 64'(last_pos_q) + 1) ?
               64'(r.position) - 64'(last_pos_q) - 1 : 0;
        region = 64'(region_cnt) + skip + 1;
        region_cnt = (region > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(region);
        row.out_position = r.position;
        row.out_base_char = r.base_char;
        if (total_mode_q) begin
            row.unique_top = clamp16(64'(uniq_cnt[0]) + uniq_cnt[1]);
            row.repeat_top = add_repeat(rep_sum[0], rep_sum[1]);
            row.raw_repeat_top = clamp16(64'(raw_cnt[0]) + raw_cnt[1]);
            row.begin_top = clamp16(64'(begin_cnt[0]) + begin_cnt[1]);
            row.unique_bot = '0;
            row.repeat_bot = '0;
            row.raw_repeat_bot = '0;
            row.begin_bot = '0;
        end else begin
            row.unique_top = uniq_cnt[0];
            row.unique_bot = uniq_cnt[1];
            row.repeat_top = rep_sum[0];
            row.repeat_bot = rep_sum[1];
            row.raw_repeat_top = raw_cnt[0];
            row.raw_repeat_bot = raw_cnt[1];
            row.begin_top = begin_cnt[0];
            row.begin_bot = begin_cnt[1];
        end
        row.skipped_positions = 32'(skip);
        row.region_positions = region_cnt;
        expected_rows = {expected_rows, row};
        last_pos_q = r.position;
        uniq_cnt = '{default: '0};
        raw_cnt = '{default: '0};
        begin_cnt = '{default: '0};
        rep_sum = '{default: '0};
    endfunction

    function automatic t_in_req make_entry(bit [31:0] pos, bit [7:0] base, bit has_al,
                                           bit del, bit [7:0] red, bit rev,
                                           bit [15:0] qpos, bit [15:0] rlen, bit last);
        t_in_req r;
        r.position = pos;
        r.base_char = base;
        r.has_alignment = has_al;
        r.is_deletion = del;
        r.redundancy = red;
        r.reversed = rev;
        r.query_position = qpos;
        r.read_len = rlen;
        r.last_in_position = last;
        return r;
    endfunction

    function automatic t_in_req random_entry(bit [31:0] pos, bit last);
        t_in_req r;
        int pick;
        r.position = pos;
        r.base_char = 8'($urandom);
        r.has_alignment = ($urandom_range(0, 9) != 0);
        r.is_deletion = ($urandom_range(0, 9) == 0);
        pick = $urandom_range(0, 99);
        r.redundancy = (pick < 50) ? 8'd1 : (pick < 58) ? 8'd0 : 8'($urandom_range(2, 255));
        r.reversed = 1'($urandom);
        r.read_len = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(1, 300));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.query_position = r.reversed ? r.read_len : 16'd1;
        else if (pick < 85)
            r.query_position = 16'($urandom_range(1, r.read_len));
        else
            r.query_position = 16'($urandom);
        r.last_in_position = last;
        return r;
    endfunction

    task automatic send_entry(t_in_req r);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        accumulate_coverage(r);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_rows.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_total_mode(bit mode);
        logic [CFG_DATA_BITS-1:0] readback;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= TOTAL_MODE_ADDR;
        pwdata <= CFG_DATA_BITS'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        total_mode_q = mode;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== CFG_DATA_BITS'(mode)) begin
            $error("total_mode: expected %0h, got %0h", mode, readback);
            failures++;
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : row_checker
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rows.size() == 0) begin
                $error("row for position %0h with no request pending",
                       o_out_req.out_position);
                failures++;
            end else begin
                want = expected_rows.pop_front();
                check_field("out_position", want.out_position, o_out_req.out_position);
                check_field("out_base_char", want.out_base_char, o_out_req.out_base_char);
                check_field("unique_top", want.unique_top, o_out_req.unique_top);
                check_field("unique_bot", want.unique_bot, o_out_req.unique_bot);
                check_field("repeat_top", want.repeat_top, o_out_req.repeat_top);
                check_field("repeat_bot", want.repeat_bot, o_out_req.repeat_bot);
                check_field("raw_repeat_top", want.raw_repeat_top, o_out_req.raw_repeat_top);
                check_field("raw_repeat_bot", want.raw_repeat_bot, o_out_req.raw_repeat_bot);
                check_field("begin_top", want.begin_top, o_out_req.begin_top);
                check_field("begin_bot", want.begin_bot, o_out_req.begin_bot);
                check_field("skipped_positions", want.skipped_positions,
                            o_out_req.skipped_positions);
                check_field("region_positions", want.region_positions,
                            o_out_req.region_positions);
            end
        end
    end

    initial begin : out_stall_gen
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                n = idle_len() + 1;
            end else begin
                n = 0;
            end
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_directed_entries();
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd1, 1'b1, 16'hFFFF, 16'hFFFF,
                              1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd50, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd2, 1'b0, 16'd1, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd3, 1'b1, 16'd100, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd255, 1'b0, 16'd7, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd0, 1'b1, 16'd7, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b1, 8'd1, 1'b0, 16'd1, 16'd100, 1'b0));
        send_entry(make_entry(32'd1, 8'h00, 1'b0, 1'b0, 8'd1, 1'b0, 16'd1, 16'd100, 1'b1));
        send_entry(make_entry(32'd0, 8'h47, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd100, 1'b1));
        send_entry(make_entry(32'd2, 8'hFF, 1'b0, 1'b0, 8'd1, 1'b0, 16'd1, 16'd100, 1'b1));
        send_entry(make_entry(32'd7, 8'h43, 1'b1, 1'b0, 8'd1, 1'b1, 16'd3, 16'd100, 1'b1));
        send_entry(make_entry(32'd5, 8'h54, 1'b1, 1'b0, 8'd4, 1'b0, 16'd3, 16'd100, 1'b1));
        send_entry(make_entry(32'd5, 8'h54, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd1, 1'b1));
        send_entry(make_entry(32'd9, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd10, 1'b0));
        send_entry(make_entry(32'h1234_5678, 8'h41, 1'b1, 1'b0, 8'd2, 1'b1, 16'd1, 16'd10,
                              1'b0));
        send_entry(make_entry(32'd0, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd10, 1'b0));
        send_entry(make_entry(32'd10, 8'h47, 1'b1, 1'b0, 8'd1, 1'b1, 16'd10, 16'd10, 1'b1));
        send_entry(make_entry(32'd11, 8'h41, 1'b0, 1'b1, 8'd1, 1'b0, 16'd1, 16'd10, 1'b0));
        send_entry(make_entry(32'd11, 8'h41, 1'b1, 1'b0, 8'd1, 1'b1, 16'd0, 16'd0, 1'b0));
        send_entry(make_entry(32'd11, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd0, 16'd0, 1'b0));
        send_entry(make_entry(32'd11, 8'h41, 1'b1, 1'b1, 8'd0, 1'b1, 16'd0, 16'd0, 1'b1));
        settle();
    endtask

    task automatic test_total_mode();
        bit [31:0] pos;
        write_total_mode(1'b1);
        pos = following_pos();
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd1, 1'b0, 16'd4, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd1, 1'b1, 16'd7, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd2, 1'b0, 16'd1, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd5, 1'b1, 16'd2, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b0, 8'd0, 1'b1, 16'd2, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h41, 1'b1, 1'b1, 8'd1, 1'b0, 16'd1, 16'd7, 1'b0));
        send_entry(make_entry(pos, 8'h54, 1'b0, 1'b0, 8'd1, 1'b0, 16'd1, 16'd7, 1'b1));
        send_entry(make_entry(pos + 32'd3, 8'h43, 1'b1, 1'b0, 8'd1, 1'b1, 16'd7, 16'd7,
                              1'b1));
        settle();
    endtask

    task automatic test_backpressure();
        int k;
        steady = 1'b1;
        hold_cycles = 400;
        for (k = 0; k < 24; k++)
            send_entry(make_entry(following_pos(), 8'($urandom), 1'b1, 1'b0, 8'd1,
                                  1'($urandom), 16'd1, 16'd40, 1'b1));
        steady = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic(int n_items, bit mode, bit wide_pos);
        int sent;
        int kind;
        int len;
        int k;
        bit mixed;
        bit [31:0] pos;
        longint unsigned nxt;
        write_total_mode(mode);
        sent = 0;
        while (sent < n_items) begin
            steady = ($urandom_range(0, 19) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_entry(random_entry(32'd0, 1'($urandom)));
            end else begin
                if (kind < 80) begin
                    k = $urandom_range(0, 9);
                    nxt = 64'(last_pos_q) + ((k < 6) ? 1 : (k < 9) ? $urandom_range(2, 5)
                                                           : $urandom_range(6, 2000));
                    pos = (nxt > 64'hFFFF_FFFF) ? 32'd1 : 32'(nxt);
                end else if (kind < 88) begin
                    pos = (last_pos_q > 1) ? $urandom_range(1, last_pos_q) : 32'd1;
                end else if (kind < 94 && wide_pos) begin
                    pos = $urandom;
                    if (pos == 0) pos = 32'd1;
                end else begin
                    pos = following_pos();
                end
                mixed = ($urandom_range(0, 19) == 0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    if (k == len - 1) begin
                        send_entry(random_entry(pos, 1'b1));
                    end else if (mixed) begin
                        send_entry(random_entry(32'($urandom_range(0, 3000)), 1'b0));
                    end else begin
                        send_entry(random_entry(pos, 1'b0));
                    end
                end
                sent += len;
            end
        end
        steady = 1'b0;
        settle();
    endtask

    task automatic test_repeat_saturation();
        int k;
        bit [31:0] pos;
        steady = 1'b1;
        write_total_mode(1'b1);
        pos = following_pos();
        for (k = 0; k < 260; k++)
            send_entry(make_entry(pos, 8'h47, 1'b1, 1'b0, 8'd0, 1'(k % 2), 16'd5, 16'd10,
                                  k == 259));
        settle();
        write_total_mode(1'b0);
        pos = following_pos();
        for (k = 0; k < 260; k++)
            send_entry(make_entry(pos, 8'h43, 1'b1, 1'b0, 8'd0, 1'b0, 16'd5, 16'd10, 1'b0));
        for (k = 0; k < 3; k++)
            send_entry(make_entry(pos, 8'h43, 1'b1, 1'b0, 8'd2, 1'b1, 16'd5, 16'd10,
                                  k == 2));
        steady = 1'b0;
        settle();
    endtask

    task automatic test_position_extremes();
        send_entry(make_entry(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b0, 8'd1, 1'b0, 16'hFFFF,
                              16'hFFFF, 1'b1));
        send_entry(make_entry(32'd1, 8'h41, 1'b1, 1'b0, 8'd1, 1'b1, 16'd1, 16'd2, 1'b1));
        send_entry(make_entry(32'hFFFF_FFFF, 8'h54, 1'b1, 1'b0, 8'hFF, 1'b1, 16'd1, 16'd2,
                              1'b1));
        send_entry(make_entry(32'd2, 8'h43, 1'b1, 1'b0, 8'd1, 1'b0, 16'd1, 16'd2, 1'b1));
        settle();
    endtask

    initial begin : test_sequence
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_entries();
        test_total_mode();
        test_backpressure();
        test_random_traffic(300, 1'b0, 1'b0);
        test_random_traffic(300, 1'b1, 1'b0);
        test_repeat_saturation();
        test_random_traffic(300, 1'b0, 1'b1);
        test_position_extremes();
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
